// ===== rtl/core/ttw_pkg.sv =====
// ttw_pkg: constants and helper functions shared by the text terminal writer
// covers the control bytes, default colors, screen defaults and hex decoding
// depends on nothing
`default_nettype none

package ttw_pkg;

   // screen geometry defaults
   localparam int DefaultColumns = 80;
   localparam int DefaultRows    = 25;

   // depth of the queue between front and back
   localparam int QueueDepth = 4;

   // control bytes
   localparam logic [7:0] EscByte     = 8'h1B;
   localparam logic [7:0] NewlineByte = 8'h0A;
   localparam logic [7:0] ColorCmd    = 8'h2A;

   // colors
   localparam logic [7:0] DefaultColor = 8'h07;
   localparam logic [3:0] DefaultFg    = 4'h7;

   // width of one queued result for a given position width
   function automatic int item_width(input int pos_width);
      return 2 * pos_width + 28;
   endfunction

   // hex digit decode: {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] ch);
      logic [4:0] res;
      res = 5'd0;
      if (ch inside {[8'h30:8'h39]}) begin
         res = {1'b1, ch[3:0]};
      end else if ((ch inside {[8'h61:8'h66]}) || (ch inside {[8'h41:8'h46]})) begin
         res = {1'b1, 4'(ch[3:0] + 4'd9)};
      end
      return res;
   endfunction

   // attribute from background and foreground digits, invalid digits fall back
   function automatic logic [7:0] color_from(input logic [7:0] bg_ch,
                                             input logic [7:0] fg_ch);
      logic [4:0] bg;
      logic [4:0] fg;
      logic [3:0] bg_nib;
      logic [3:0] fg_nib;
      bg     = hex_digit(bg_ch);
      fg     = hex_digit(fg_ch);
      bg_nib = bg[4] ? bg[3:0] : 4'h0;
      fg_nib = fg[4] ? fg[3:0] : DefaultFg;
      return {bg_nib, fg_nib};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ttw_ram.sv =====
// ttw_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ttw_ram #(
   parameter int Width = 16,
   parameter int Depth = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ttw_front.sv =====
// ttw_front: accepts terminal bytes, runs the escape parser, tracks position and color
// builds one result beat per byte for the back end; uses ttw_pkg
`default_nettype none

module ttw_front
   import ttw_pkg::*;
#(
   parameter int Columns = DefaultColumns,
   parameter int Rows    = DefaultRows
) (
   input  wire logic                                            clock,
   input  wire logic                                            reset,
   input  wire logic                                            push,
   input  wire logic                                            can_take,
   input  wire logic [7:0]                                      byte_in,
   input  wire logic                                            last_of_write,
   input  wire logic                                            cursor_en,
   output      logic                                            enq,
   output      logic [item_width($clog2(Columns*Rows))-1:0]     item
);

   localparam int PosWidth  = $clog2(Columns * Rows);
   localparam int ColWidth  = (Columns > 1) ? $clog2(Columns) : 1;
   localparam logic [ColWidth-1:0] ColLast     = ColWidth'(Columns - 1);
   localparam logic [PosWidth-1:0] LastRowBase = PosWidth'(Columns * Rows - Columns);

   // escape phases
   localparam logic [1:0] PhaseNormal = 2'd0;
   localparam logic [1:0] PhaseCmd    = 2'd1;
   localparam logic [1:0] PhaseArg1   = 2'd2;
   localparam logic [1:0] PhaseArg2   = 2'd3;

   typedef struct packed {
      logic                written;
      logic [PosWidth-1:0] idx;
      logic [15:0]         value;
      logic [PosWidth-1:0] pos;
      logic                visible;
      logic                scrolled;
      logic [7:0]          color;
      logic                done;
   } item_type;

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [PosWidth-1:0] rowbase_ff, rowbase_in;
   logic [ColWidth-1:0] col_ff, col_in;
   logic [7:0]          color_ff, color_in;
   logic [1:0]          phase_ff, phase_in;
   logic [7:0]          first_arg_ff, first_arg_in;
   logic [PosWidth-1:0] next_row;
   item_type            item_in;

   assign enq      = push & can_take;
   assign next_row = PosWidth'(rowbase_ff + PosWidth'(Columns));

   // parse one byte and work out the next position and color
   always_comb begin
      pos_in       = pos_ff;
      rowbase_in   = rowbase_ff;
      col_in       = col_ff;
      color_in     = color_ff;
      phase_in     = phase_ff;
      first_arg_in = first_arg_ff;
      item_in      = '0;
      case (phase_ff)
         PhaseCmd: begin
            phase_in = (byte_in == ColorCmd) ? PhaseArg1 : PhaseNormal;
         end
         PhaseArg1: begin
            first_arg_in = byte_in;
            phase_in     = PhaseArg2;
         end
         PhaseArg2: begin
            color_in     = color_from(first_arg_ff, byte_in);
            first_arg_in = 8'd0;
            phase_in     = PhaseNormal;
         end
         default: begin
            if (byte_in == EscByte) begin
               phase_in = PhaseCmd;
            end else if (byte_in == NewlineByte) begin
               col_in = '0;
               if (rowbase_ff == LastRowBase) begin
                  item_in.scrolled = 1'b1;
                  pos_in           = LastRowBase;
               end else begin
                  pos_in     = next_row;
                  rowbase_in = next_row;
               end
            end else begin
               item_in.written = 1'b1;
               item_in.idx     = pos_ff;
               item_in.value   = {color_ff, byte_in};
               if (col_ff == ColLast) begin
                  col_in = '0;
                  if (rowbase_ff == LastRowBase) begin
                     item_in.scrolled = 1'b1;
                     pos_in           = LastRowBase;
                  end else begin
                     pos_in     = next_row;
                     rowbase_in = next_row;
                  end
               end else begin
                  col_in = ColWidth'(col_ff + 1'b1);
                  pos_in = PosWidth'(pos_ff + 1'b1);
               end
            end
         end
      endcase
      item_in.pos     = pos_in;
      item_in.visible = cursor_en;
      item_in.color   = color_in;
      item_in.done    = last_of_write;
   end

   assign item = item_in;

   // terminal state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rowbase_ff   <= '0;
         col_ff       <= '0;
         color_ff     <= DefaultColor;
         phase_ff     <= PhaseNormal;
         first_arg_ff <= 8'd0;
      end else if (enq) begin
         pos_ff       <= pos_in;
         rowbase_ff   <= rowbase_in;
         col_ff       <= col_in;
         color_ff     <= color_in;
         phase_ff     <= phase_in;
         first_arg_ff <= first_arg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ttw_queue.sv =====
// ttw_queue: short register queue between the front and back ends
// no dependencies
`default_nettype none

module ttw_queue #(
   parameter int Width = 50,
   parameter int Depth = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr,
   input  wire logic [Width-1:0] wr_data,
   input  wire logic             rd,
   output      logic [Width-1:0] head,
   output      logic             full,
   output      logic             empty
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   logic [Width-1:0]    slot_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   assign full  = (count_ff == CntWidth'(Depth));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : PtrWidth'(wr_ptr_ff + 1'b1);
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : PtrWidth'(rd_ptr_ff + 1'b1);
      end
      if (wr && !rd) begin
         count_in = CntWidth'(count_ff + 1'b1);
      end else if (rd && !wr) begin
         count_in = CntWidth'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ttw_back.sv =====
// ttw_back: carries out cell writes, scroll copies and the reset clear of the screen ram
// holds the result register; uses ttw_pkg and ttw_ram
`default_nettype none

module ttw_back
   import ttw_pkg::*;
#(
   parameter int Columns = DefaultColumns,
   parameter int Rows    = DefaultRows
) (
   input  wire logic                                            clock,
   input  wire logic                                            reset,
   input  wire logic [item_width($clog2(Columns*Rows))-1:0]     head,
   input  wire logic                                            head_valid,
   output      logic                                            q_pop,
   output      logic                                            clearing,
   input  wire logic                                            out_pop,
   output      logic                                            out_valid,
   output      logic [item_width($clog2(Columns*Rows))-1:0]     out_item
);

   localparam int PosWidth  = $clog2(Columns * Rows);
   localparam int ItemWidth = item_width(PosWidth);
   localparam logic [PosWidth-1:0] CellLast = PosWidth'(Columns * Rows - 1);
   localparam logic [PosWidth-1:0] CopyLen  = PosWidth'(Columns * Rows - Columns);

   // sequencer states
   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StClear  = 3'd1;
   localparam logic [2:0] StCopy   = 3'd2;
   localparam logic [2:0] StBlank  = 3'd3;
   localparam logic [2:0] StFinish = 3'd4;

   typedef struct packed {
      logic                written;
      logic [PosWidth-1:0] idx;
      logic [15:0]         value;
      logic [PosWidth-1:0] pos;
      logic                visible;
      logic                scrolled;
      logic [7:0]          color;
      logic                done;
   } item_type;

   item_type            head_item;
   logic [2:0]          state_ff, state_in;
   logic [PosWidth-1:0] cnt_ff, cnt_in;
   logic                out_vld_ff, out_vld_in;
   logic [ItemWidth-1:0] out_item_ff;
   logic                rsp_pop;
   logic                out_free;
   logic                load;
   logic                wr_en;
   logic [PosWidth-1:0] wr_addr;
   logic [15:0]         wr_data;
   logic                rd_en;
   logic [PosWidth-1:0] rd_addr;
   logic [15:0]         rd_data;

   assign head_item = head;
   assign rsp_pop   = out_pop & out_vld_ff;
   assign out_free  = ~out_vld_ff | rsp_pop;
   assign clearing  = (state_ff == StClear);

   // screen store
   ttw_ram #(
      .Width (16),
      .Depth (Columns * Rows)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer: clear after reset, cell writes, scroll copy then blank bottom row
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      wr_en    = 1'b0;
      wr_addr  = cnt_ff;
      wr_data  = 16'd0;
      rd_en    = 1'b0;
      rd_addr  = PosWidth'({1'b0, cnt_ff} + (PosWidth + 1)'(Columns));
      q_pop    = 1'b0;
      load     = 1'b0;
      case (state_ff)
         StClear: begin
            wr_en = 1'b1;
            if (cnt_ff == CellLast) begin
               state_in = StIdle;
               cnt_in   = '0;
            end else begin
               cnt_in = PosWidth'(cnt_ff + 1'b1);
            end
         end
         StIdle: begin
            wr_addr = head_item.idx;
            wr_data = head_item.value;
            if (head_valid) begin
               if (head_item.scrolled) begin
                  wr_en    = head_item.written;
                  state_in = StCopy;
                  cnt_in   = '0;
               end else if (out_free) begin
                  wr_en = head_item.written;
                  q_pop = 1'b1;
                  load  = 1'b1;
               end
            end
         end
         StCopy: begin
            // read one row down, write the cell read last cycle
            rd_en   = (cnt_ff != CopyLen);
            wr_en   = (cnt_ff != '0);
            wr_addr = PosWidth'(cnt_ff - 1'b1);
            wr_data = rd_data;
            if (cnt_ff == CopyLen) begin
               state_in = StBlank;
            end else begin
               cnt_in = PosWidth'(cnt_ff + 1'b1);
            end
         end
         StBlank: begin
            wr_en = 1'b1;
            if (cnt_ff == CellLast) begin
               state_in = StFinish;
            end else begin
               cnt_in = PosWidth'(cnt_ff + 1'b1);
            end
         end
         StFinish: begin
            if (out_free) begin
               q_pop    = 1'b1;
               load     = 1'b1;
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   assign out_vld_in = load | (out_vld_ff & ~rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= StClear;
         cnt_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load) begin
         out_item_ff <= head;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_item  = out_item_ff;

   // reset always starts a full clear from cell zero
   assert property (@(posedge clock) reset |=> (state_ff == StClear) && (cnt_ff == '0))
      else $error("clear pass does not start after reset");

   // a beat only leaves the queue when one is there
   assert property (@(posedge clock) disable iff (reset) q_pop |-> head_valid)
      else $error("queue popped while empty");

   // a scrolling beat is released only after the copy and blank are done
   assert property (@(posedge clock) disable iff (reset)
      (q_pop && head_item.scrolled) |-> (state_ff == StFinish))
      else $error("scroll beat released before copy finished");

   // copy never reads the cell it writes
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StCopy && rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("copy read and write collide");

   // blanking stays in the bottom row
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StBlank) |-> (cnt_ff >= CopyLen))
      else $error("blank outside bottom row");

endmodule

`default_nettype wire

// ===== rtl/core/text_terminal_writer.sv =====
// text_terminal_writer: top level of the text terminal writer
// ties front end, queue and back end together; uses ttw_pkg, ttw_front, ttw_queue, ttw_back
//
// usage:
//   input: drive req_byte_in and req_last_of_write with push; a beat is taken
//   at a clock edge with push high and full low. results: while empty is low
//   the oldest result is on the rsp_ ports; it is taken at an edge with pop
//   high. every byte gives exactly one result beat, escape bytes included.
//   csr_wr_en with csr_wr_data sets cursor enable (reset 1); write it only
//   while the block is idle.
//   with the queue and result register empty, a taken byte goes into the
//   queue and is then loaded into the result register. ordinary bytes run
//   at 1 per cycle while the receiver keeps popping, set by the single
//   write port of the screen ram. a byte that scrolls first writes its cell;
//   the back end then copies the rows up through the registered ram read and
//   blanks the bottom row before it releases the result; the front keeps
//   taking bytes until the 4 entry queue fills. reset: synchronous;
//   afterwards full stays high while the screen ram is cleared one cell a
//   cycle. a stalled receiver holds the result register; the queue then
//   fills and full goes high.
`default_nettype none

module text_terminal_writer
   import ttw_pkg::*;
#(
   parameter int Columns = DefaultColumns,
   parameter int Rows    = DefaultRows
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   output      logic                                 full,
   input  wire logic [7:0]                           req_byte_in,
   input  wire logic                                 req_last_of_write,
   output      logic                                 empty,
   input  wire logic                                 pop,
   output      logic                                 rsp_cell_written,
   output      logic [$clog2(Columns*Rows)-1:0]      rsp_cell_index,
   output      logic [15:0]                          rsp_cell_value,
   output      logic [$clog2(Columns*Rows)-1:0]      rsp_cursor_position,
   output      logic                                 rsp_cursor_visible,
   output      logic                                 rsp_scrolled,
   output      logic [7:0]                           rsp_current_color,
   output      logic                                 rsp_write_done,
   input  wire logic                                 csr_wr_en,
   input  wire logic                                 csr_wr_data
);

   localparam int PosWidth  = $clog2(Columns * Rows);
   localparam int ItemWidth = item_width(PosWidth);

   typedef struct packed {
      logic                written;
      logic [PosWidth-1:0] idx;
      logic [15:0]         value;
      logic [PosWidth-1:0] pos;
      logic                visible;
      logic                scrolled;
      logic [7:0]          color;
      logic                done;
   } item_type;

   logic                 cursor_en_ff;
   logic                 enq;
   logic [ItemWidth-1:0] front_item;
   logic [ItemWidth-1:0] q_head;
   logic                 q_full;
   logic                 q_empty;
   logic                 q_pop;
   logic                 clearing;
   logic                 out_valid;
   logic [ItemWidth-1:0] out_item;
   item_type             rsp;

   // cursor enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_en_ff <= 1'b1;
      end else if (csr_wr_en) begin
         cursor_en_ff <= csr_wr_data;
      end
   end

   assign full = q_full | clearing;

   // front end: parser and position tracking
   ttw_front #(
      .Columns (Columns),
      .Rows    (Rows)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .can_take      (~full),
      .byte_in       (req_byte_in),
      .last_of_write (req_last_of_write),
      .cursor_en     (cursor_en_ff),
      .enq           (enq),
      .item          (front_item)
   );

   // queue between front and back
   ttw_queue #(
      .Width (ItemWidth),
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (enq),
      .wr_data (front_item),
      .rd      (q_pop),
      .head    (q_head),
      .full    (q_full),
      .empty   (q_empty)
   );

   // back end: screen ram and result register
   ttw_back #(
      .Columns (Columns),
      .Rows    (Rows)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .head_valid (~q_empty),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .out_pop    (pop),
      .out_valid  (out_valid),
      .out_item   (out_item)
   );

   // result beat on the ports
   assign rsp                 = out_item;
   assign empty               = ~out_valid;
   assign rsp_cell_written    = rsp.written;
   assign rsp_cell_index      = rsp.idx;
   assign rsp_cell_value      = rsp.value;
   assign rsp_cursor_position = rsp.pos;
   assign rsp_cursor_visible  = rsp.visible;
   assign rsp_scrolled        = rsp.scrolled;
   assign rsp_current_color   = rsp.color;
   assign rsp_write_done      = rsp.done;

endmodule

`default_nettype wire

// ===== dv/text_terminal_writer_test.sv =====
// text_terminal_writer_test: self-checking bench for the text terminal writer
// a scoreboard class predicts one result beat per byte; depends on ttw_pkg and
// text_terminal_writer
`timescale 1ns / 1ps

module text_terminal_writer_test
   import ttw_pkg::*;
;

   localparam int Columns    = DefaultColumns;
   localparam int Rows       = DefaultRows;
   localparam int Cells      = Columns * Rows;
   localparam int PosWidth   = $clog2(Cells);
   localparam int CycleLimit = 5000000;
   localparam int PhaseCount = 5;
   localparam int PhaseBytes = 110;
   localparam int OpeningLen = 28;

   // opening text: extreme bytes, a newline, then color and escape corners
   localparam logic [7:0] OpeningText [OpeningLen] = '{
      "A", 8'h00, 8'hFF, NewlineByte,
      EscByte, ColorCmd, "9", "a",
      EscByte, ColorCmd, "F", "f",
      EscByte, ColorCmd, "g", "A",
      EscByte, ColorCmd, "B", "@",
      EscByte, ColorCmd, NewlineByte, EscByte,
      EscByte, NewlineByte,
      EscByte, EscByte
   };

   typedef enum logic [1:0] {
      PhaseNormal,
      PhaseCommand,
      PhaseFirstArg,
      PhaseSecondArg
   } escape_phase_type;

   typedef struct packed {
      logic                cell_written;
      logic [PosWidth-1:0] cell_index;
      logic [15:0]         cell_value;
      logic [PosWidth-1:0] cursor_position;
      logic                cursor_visible;
      logic                scrolled;
      logic [7:0]          current_color;
      logic                write_done;
   } screen_beat_type;

   // terminal state mirror and the beats it still owes
   class terminal_scoreboard;
      int               position;
      logic [7:0]       color;
      escape_phase_type phase;
      logic [7:0]       command;
      logic [7:0]       first_arg;
      logic             cursor_en;
      screen_beat_type  screen_updates[$];
      int               errors;

      function new();
         position  = 0;
         color     = DefaultColor;
         cursor_en = 1'b1;
         errors    = 0;
         close_escape();
      endfunction

      function void close_escape();
         phase     = PhaseNormal;
         command   = 8'h00;
         first_arg = 8'h00;
      endfunction

      // digit value, -1 when the byte is not a hex digit
      function int hex_nibble(logic [7:0] ch);
         if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
         if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
         if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
         return -1;
      endfunction

      // past the last cell: scroll up and park at the start of the bottom row
      function logic wrap_at_bottom();
         if (position >= Cells) begin
            position = Cells - Columns;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_byte(logic [7:0] ch, logic last);
         screen_beat_type beat;
         int              bg;
         int              fg;
         beat = '0;
         if (position >= Cells) position = 0;
         case (phase)
            PhaseCommand: begin
               command = ch;
               if (ch == ColorCmd) phase = PhaseFirstArg;
               else close_escape();
            end
            PhaseFirstArg: begin
               first_arg = ch;
               phase     = PhaseSecondArg;
            end
            PhaseSecondArg: begin
               // invalid background falls to 0, invalid foreground to the default
               bg = hex_nibble(first_arg);
               fg = hex_nibble(ch);
               if (bg < 0) bg = 0;
               if (fg < 0) fg = int'(DefaultFg);
               color = {bg[3:0], fg[3:0]};
               close_escape();
            end
            default: begin
               if (ch == EscByte) begin
                  phase = PhaseCommand;
               end else if (ch == NewlineByte) begin
                  position      = position + Columns - position % Columns;
                  beat.scrolled = wrap_at_bottom();
               end else begin
                  beat.cell_written = 1'b1;
                  beat.cell_index   = PosWidth'(position);
                  beat.cell_value   = {color, ch};
                  position          = position + 1;
                  beat.scrolled     = wrap_at_bottom();
               end
            end
         endcase
         beat.cursor_position = PosWidth'(position);
         beat.cursor_visible  = cursor_en;
         beat.current_color   = color;
         beat.write_done      = last;
         screen_updates.push_back(beat);
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_beat(screen_beat_type got);
         screen_beat_type want;
         if (screen_updates.size() == 0) begin
            $display("%0t: result beat with nothing expected, expected none actual 0x%0h",
                     $time, got);
            errors++;
            return;
         end
         want = screen_updates.pop_front();
         compare_field("cell_written", want.cell_written, got.cell_written);
         compare_field("cell_index", want.cell_index, got.cell_index);
         compare_field("cell_value", want.cell_value, got.cell_value);
         compare_field("cursor_position", want.cursor_position, got.cursor_position);
         compare_field("cursor_visible", want.cursor_visible, got.cursor_visible);
         compare_field("scrolled", want.scrolled, got.scrolled);
         compare_field("current_color", want.current_color, got.current_color);
         compare_field("write_done", want.write_done, got.write_done);
      endfunction
   endclass

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                push              = 1'b0;
   logic                full;
   logic [7:0]          req_byte_in       = 8'h00;
   logic                req_last_of_write = 1'b0;
   logic                empty;
   logic                pop               = 1'b0;
   logic                rsp_cell_written;
   logic [PosWidth-1:0] rsp_cell_index;
   logic [15:0]         rsp_cell_value;
   logic [PosWidth-1:0] rsp_cursor_position;
   logic                rsp_cursor_visible;
   logic                rsp_scrolled;
   logic [7:0]          rsp_current_color;
   logic                rsp_write_done;
   logic                csr_wr_en         = 1'b0;
   logic                csr_wr_data       = 1'b0;

   terminal_scoreboard sb = new();
   int cycle_count = 0;
   int bytes_sent  = 0;
   int tx_burst    = 0;
   int rx_burst    = 0;

   text_terminal_writer #(
      .Columns(Columns),
      .Rows   (Rows)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_byte_in        (req_byte_in),
      .req_last_of_write  (req_last_of_write),
      .empty              (empty),
      .pop                (pop),
      .rsp_cell_written   (rsp_cell_written),
      .rsp_cell_index     (rsp_cell_index),
      .rsp_cell_value     (rsp_cell_value),
      .rsp_cursor_position(rsp_cursor_position),
      .rsp_cursor_visible (rsp_cursor_visible),
      .rsp_scrolled       (rsp_scrolled),
      .rsp_current_color  (rsp_current_color),
      .rsp_write_done     (rsp_write_done),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // idle length: mostly none or short, a few long, with idle-free runs
   function automatic int pick_gap(inout int burst);
      int roll;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         burst = $urandom_range(20, 60);
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // mostly valid hex digits in both cases, sometimes any byte
   function automatic logic [7:0] pick_digit();
      int k;
      if ($urandom_range(0, 99) >= 85) return 8'($urandom_range(0, 255));
      k = $urandom_range(0, 21);
      if (k < 10) return 8'(int'("0") + k);
      if (k < 16) return 8'(int'("a") + k - 10);
      return 8'(int'("A") + k - 16);
   endfunction

   // one input beat
   task automatic send_byte(input logic [7:0] value, input logic last);
      int gap;
      gap = pick_gap(tx_burst);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push              <= 1'b1;
      req_byte_in       <= value;
      req_last_of_write <= last;
      do @(posedge clock); while (full);
      sb.note_byte(value, last);
      bytes_sent++;
   endtask

   // random text: plain bytes, newlines, color sequences, other commands, noise
   task automatic send_random_item();
      int pick;
      int extra;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      end else if (pick < 70) begin
         send_byte(NewlineByte, $urandom_range(0, 5) == 0);
      end else if (pick < 88) begin
         send_byte(EscByte, $urandom_range(0, 7) == 0);
         send_byte(ColorCmd, $urandom_range(0, 7) == 0);
         send_byte(pick_digit(), $urandom_range(0, 7) == 0);
         send_byte(pick_digit(), $urandom_range(0, 3) == 0);
      end else if (pick < 94) begin
         send_byte(EscByte, 1'b0);
         send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
         // broken sequence: escape followed by a few arbitrary bytes
         extra = $urandom_range(1, 3);
         send_byte(EscByte, $urandom_range(0, 5) == 0);
         repeat (extra) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      end
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (sb.screen_updates.size() != 0) @(posedge clock);
   endtask

   task automatic write_cursor_enable(input logic value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      sb.cursor_en = value;
   endtask

   // result side: random stalls, check every accepted beat
   initial begin : result_drain
      int              stall;
      screen_beat_type got;
      wait (reset == 1'b0);
      forever begin
         stall = pick_gap(rx_burst);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         got.cell_written    = rsp_cell_written;
         got.cell_index      = rsp_cell_index;
         got.cell_value      = rsp_cell_value;
         got.cursor_position = rsp_cursor_position;
         got.cursor_visible  = rsp_cursor_visible;
         got.scrolled        = rsp_scrolled;
         got.current_color   = rsp_current_color;
         got.write_done      = rsp_write_done;
         sb.check_beat(got);
      end
   end

   // stimulus: reset, opening text at reset cursor enable, then random phases
   initial begin : stimulus
      int quota;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < OpeningLen; i++) begin
         send_byte(OpeningText[i], i == 2 || i == 5);
      end
      wait_drained();

      for (int p = 0; p < PhaseCount; p++) begin
         write_cursor_enable(p % 2 == 1);
         quota = bytes_sent + PhaseBytes;
         while (bytes_sent < quota) send_random_item();
         wait_drained();
      end

      // allow for stray beats after the last one
      repeat (20) @(posedge clock);
      if (sb.screen_updates.size() != 0) begin
         $display("%0t: beats never arrived, expected 0 pending actual %0d",
                  $time, sb.screen_updates.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/ttw_pkg.sv
rtl/core/ttw_ram.sv
rtl/core/ttw_front.sv
rtl/core/ttw_queue.sv
rtl/core/ttw_back.sv
rtl/core/text_terminal_writer.sv
dv/text_terminal_writer_test.sv
